FILE: design/pfill_pkg.sv
`default_nettype none

package pfill_pkg;

    localparam int COORD_BITS      = 12;
    localparam int CFG_BITS        = 13;
    localparam int MAX_RESULTS     = 32;
    localparam int DEF_MAX_EDGES   = 64;
    localparam int DEF_FRAC_BITS   = 16;
    localparam logic [CFG_BITS-1:0] ROW_MAX       = 13'd8191;
    localparam logic [CFG_BITS-1:0] ROW_COUNT_RST = 13'd400;
    localparam logic [CFG_BITS-1:0] LINE_WIDTH_RST = 13'd400;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_LOAD   = 2'd1,
        KIND_RENDER = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic {
        CFG_ROW_COUNT  = 1'b0,
        CFG_LINE_WIDTH = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]            kind;
        logic [COORD_BITS-1:0] x_a;
        logic [COORD_BITS-1:0] y_a;
        logic [COORD_BITS-1:0] x_b;
        logic [COORD_BITS-1:0] y_b;
    } in_word_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] x_left;
        logic [COORD_BITS-1:0] x_right;
        logic                  has_span;
        logic                  last_of_row;
        logic                  overflow;
        logic                  done_res;
    } out_word_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DONE_OUT,
        ST_SPN_RD,
        ST_SPN_RD2,
        ST_SPN_CHK,
        ST_SPN_PUT,
        ST_SPN_FIN,
        ST_ACT_RD,
        ST_ACT_CHK,
        ST_DIV,
        ST_ACT_WR,
        ST_STP_RD,
        ST_STP_WR,
        ST_SRT_START,
        ST_SRT_LD0,
        ST_SRT_RD,
        ST_SRT_CMP,
        ST_NEXT_ROW
    } state_t;

endpackage

`default_nettype wire

FILE: design/polygon_scanline_fill_unit.sv
`default_nettype none

// Scanline polygon fill, edge table plus active edge list. Word kinds: clear
// (empties everything, back to row 0), load (one edge, horizontal edges dropped,
// overflow flag set when the edge store is full) and render (spans of the current
// row, then step to the next row). Clear and load give no result. Render gives
// one to 32 result words, the final one flagged last_of_row; past row_count it
// gives a single done word and changes nothing. A render word runs as a
// sequencer over two memories with registered reads (edge store, active list):
// the spans, one active pair at a time, then the hand-over of the last word; an
// activation scan over the stored edges, where each edge that turns active
// takes 28 steps of the shift-subtract divider and a write; retire and step for
// each active edge; then bubble passes until a pass makes no swap (one pass when
// the list stays ordered, at most one pass per active edge). The input stalls
// for the whole render; the output register lets the last span wait while the
// next word is taken. Config writes are always ready.
module polygon_scanline_fill_unit
#(
    parameter int MAX_EDGES = pfill_pkg::DEF_MAX_EDGES,
    parameter int FRAC_BITS = pfill_pkg::DEF_FRAC_BITS
)
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_stall,
    input  wire pfill_pkg::in_word_t     in_data,
    output logic                         out_valid,
    input  wire                          out_stall,
    output pfill_pkg::out_word_t         out_data,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire                          cfg_index,
    input  wire [pfill_pkg::CFG_BITS-1:0] cfg_data
);
    import pfill_pkg::*;

    localparam int AW     = $clog2(MAX_EDGES);
    localparam int CW     = AW + 1;                       // counts up to MAX_EDGES
    localparam int ACC_W  = COORD_BITS + FRAC_BITS + 2;   // signed x and slope
    localparam int ENT_W  = 2 * ACC_W + COORD_BITS;       // {x, slope, end}
    localparam int EDG_W  = 4 * COORD_BITS;               // {xt, yt, xb, yb}
    localparam int NUM_W  = COORD_BITS + FRAC_BITS;       // |dx| << FRAC_BITS
    localparam int DCW    = $clog2(NUM_W + 1);
    localparam int SW     = COORD_BITS + 4;               // span arithmetic
    localparam int NW     = $clog2(MAX_RESULTS + 1);
    localparam logic signed [ACC_W:0] RND = (ACC_W+1)'((64'd1 << FRAC_BITS) - 64'd1);
    localparam logic signed [SW-1:0]  X_MAX = SW'((1 << COORD_BITS) - 1);

    // memories
    logic [EDG_W-1:0] edge_mem [MAX_EDGES];
    logic [ENT_W-1:0] act_mem  [MAX_EDGES];
    logic [EDG_W-1:0] e_rd_reg;
    logic [ENT_W-1:0] a_rd_reg;
    logic             e_we, a_we;
    logic [AW-1:0]    e_wa, e_ra, a_wa, a_ra;
    logic [EDG_W-1:0] e_wd;
    logic [ENT_W-1:0] a_wd;

    always_ff @(posedge clk)
    begin
        if (e_we)
        begin
            edge_mem[e_wa] <= e_wd;
        end
        e_rd_reg <= edge_mem[e_ra];
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            act_mem[a_wa] <= a_wd;
        end
        a_rd_reg <= act_mem[a_ra];
    end

    state_t              state_reg, state_next;
    logic [CW-1:0]       edge_cnt_reg, edge_cnt_next;
    logic [CW-1:0]       act_cnt_reg, act_cnt_next;
    logic [CFG_BITS-1:0] row_reg, row_next;
    logic                ovf_reg, ovf_next;
    logic [CFG_BITS-1:0] row_count_reg, row_count_next;
    logic [CFG_BITS-1:0] line_width_reg, line_width_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       keep_reg, keep_next;
    logic [NW-1:0]       n_reg, n_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [COORD_BITS-1:0] pend_l_reg, pend_l_next, pend_r_reg, pend_r_next;
    logic                span_ok_reg, span_ok_next;
    logic [COORD_BITS-1:0] span_l_reg, span_l_next, span_r_reg, span_r_next;
    logic [ACC_W-1:0]    xl_reg, xl_next;
    logic [ENT_W-1:0]    carry_reg, carry_next;
    logic                swap_reg, swap_next;
    logic [NUM_W-1:0]    quo_reg, quo_next;
    logic [COORD_BITS-1:0] rem_reg, rem_next;
    logic [COORD_BITS-1:0] dy_reg, dy_next;
    logic [DCW-1:0]      div_cnt_reg, div_cnt_next;
    logic                neg_reg, neg_next;
    logic [COORD_BITS-1:0] xt_reg, xt_next, yb_reg, yb_next;
    logic                out_valid_reg, out_valid_next;
    out_word_t           out_reg, out_next;

    // read-data fields
    logic signed [ACC_W-1:0] rd_x, rd_s, carry_x;
    logic [COORD_BITS-1:0]   rd_end;
    logic [COORD_BITS-1:0]   e_xt, e_yt, e_xb, e_yb;

    assign rd_x    = a_rd_reg[ENT_W-1 -: ACC_W];
    assign rd_s    = a_rd_reg[ENT_W-ACC_W-1 -: ACC_W];
    assign rd_end  = a_rd_reg[COORD_BITS-1:0];
    assign carry_x = carry_reg[ENT_W-1 -: ACC_W];
    assign e_xt    = e_rd_reg[4*COORD_BITS-1 -: COORD_BITS];
    assign e_yt    = e_rd_reg[3*COORD_BITS-1 -: COORD_BITS];
    assign e_xb    = e_rd_reg[2*COORD_BITS-1 -: COORD_BITS];
    assign e_yb    = e_rd_reg[COORD_BITS-1:0];

    // span arithmetic: left = ceil(x0), right = ceil(x1) - 1, clipped
    logic signed [ACC_W:0]   cl_sum, cr_sum, cl_sh, cr_sh;
    logic signed [SW-1:0]    l_s, r_s, hi_s;
    always_comb
    begin
        cl_sum = $signed({xl_reg[ACC_W-1], xl_reg}) + RND;
        cr_sum = $signed({rd_x[ACC_W-1], rd_x}) + RND;
        cl_sh  = cl_sum >>> FRAC_BITS;
        cr_sh  = cr_sum >>> FRAC_BITS;
        l_s    = SW'(cl_sh);
        r_s    = SW'(cr_sh) - SW'(1);
        hi_s   = $signed(SW'({1'b0, line_width_reg})) - SW'(1);
        if (hi_s > X_MAX)
        begin
            hi_s = X_MAX;
        end
        if (l_s < 0)
        begin
            l_s = '0;
        end
        if (r_s > hi_s)
        begin
            r_s = hi_s;
        end
    end

    // step with saturation
    logic signed [ACC_W:0]   step_sum;
    logic signed [ACC_W-1:0] step_x;
    always_comb
    begin
        step_sum = $signed({rd_x[ACC_W-1], rd_x}) + $signed({rd_s[ACC_W-1], rd_s});
        if (step_sum[ACC_W] != step_sum[ACC_W-1])
        begin
            step_x = step_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                     : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            step_x = step_sum[ACC_W-1:0];
        end
    end

    // divider step
    logic [COORD_BITS:0] div_rs;
    assign div_rs = {rem_reg, quo_reg[NUM_W-1]};

    logic slot_free;
    assign slot_free = !out_valid_reg || !out_stall;

    logic [COORD_BITS-1:0] ld_xt, ld_yt, ld_xb, ld_yb;
    logic [COORD_BITS:0]   dx_s;
    logic [ACC_W-1:0]      slope_w;

    always_comb
    begin
        state_next      = state_reg;
        edge_cnt_next   = edge_cnt_reg;
        act_cnt_next    = act_cnt_reg;
        row_next        = row_reg;
        ovf_next        = ovf_reg;
        row_count_next  = row_count_reg;
        line_width_next = line_width_reg;
        idx_next        = idx_reg;
        keep_next       = keep_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_l_next     = pend_l_reg;
        pend_r_next     = pend_r_reg;
        span_ok_next    = span_ok_reg;
        span_l_next     = span_l_reg;
        span_r_next     = span_r_reg;
        xl_next         = xl_reg;
        carry_next      = carry_reg;
        swap_next       = swap_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        dy_next         = dy_reg;
        div_cnt_next    = div_cnt_reg;
        neg_next        = neg_reg;
        xt_next         = xt_reg;
        yb_next         = yb_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_next        = out_reg;
        e_we = 1'b0;
        e_wa = edge_cnt_reg[AW-1:0];
        e_wd = '0;
        e_ra = idx_reg[AW-1:0];
        a_we = 1'b0;
        a_wa = keep_reg[AW-1:0];
        a_wd = '0;
        a_ra = idx_reg[AW-1:0];
        in_stall  = (state_reg != ST_IDLE);
        cfg_ready = 1'b1;
        ld_xt = in_data.x_a;
        ld_yt = in_data.y_a;
        ld_xb = in_data.x_b;
        ld_yb = in_data.y_b;
        dx_s    = '0;
        slope_w = '0;

        if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ROW_COUNT:  row_count_next  = cfg_data;
                CFG_LINE_WIDTH: line_width_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (kind_t'(in_data.kind))
                        KIND_CLEAR:
                        begin
                            edge_cnt_next = '0;
                            act_cnt_next  = '0;
                            row_next      = '0;
                            ovf_next      = 1'b0;
                        end
                        KIND_LOAD:
                        begin
                            if (in_data.y_a > in_data.y_b)
                            begin
                                ld_xt = in_data.x_b;
                                ld_yt = in_data.y_b;
                                ld_xb = in_data.x_a;
                                ld_yb = in_data.y_a;
                            end
                            if (in_data.y_a != in_data.y_b)
                            begin
                                if (edge_cnt_reg >= CW'(MAX_EDGES))
                                begin
                                    ovf_next = 1'b1;
                                end
                                else
                                begin
                                    e_we = 1'b1;
                                    e_wd = {ld_xt, ld_yt, ld_xb, ld_yb};
                                    edge_cnt_next = edge_cnt_reg + CW'(1);
                                end
                            end
                        end
                        KIND_RENDER:
                        begin
                            if (row_reg >= row_count_reg)
                            begin
                                state_next = ST_DONE_OUT;
                            end
                            else
                            begin
                                idx_next        = '0;
                                n_next          = '0;
                                pend_valid_next = 1'b0;
                                state_next      = ST_SPN_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_DONE_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_next = '{row: '0, x_left: '0, x_right: '0, has_span: 1'b0,
                                 last_of_row: 1'b1, overflow: ovf_reg, done_res: 1'b1};
                    state_next = ST_IDLE;
                end
            end

            // span emission, one pair at a time
            ST_SPN_RD:
            begin
                if (({1'b0, idx_reg} + (CW+1)'(1) < {1'b0, act_cnt_reg}) &&
                    (n_reg < NW'(MAX_RESULTS)))
                begin
                    state_next = ST_SPN_RD2;
                end
                else
                begin
                    state_next = ST_SPN_FIN;
                end
            end

            ST_SPN_RD2:
            begin
                xl_next    = rd_x;
                a_ra       = AW'(idx_reg + CW'(1));
                state_next = ST_SPN_CHK;
            end

            ST_SPN_CHK:
            begin
                span_ok_next = !(l_s > r_s);
                span_l_next  = l_s[COORD_BITS-1:0];
                span_r_next  = r_s[COORD_BITS-1:0];
                state_next   = ST_SPN_PUT;
            end

            ST_SPN_PUT:
            begin
                if (!span_ok_reg)
                begin
                    idx_next   = idx_reg + CW'(2);
                    state_next = ST_SPN_RD;
                end
                else if (!pend_valid_reg || slot_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_next = '{row: row_reg[COORD_BITS-1:0], x_left: pend_l_reg,
                                     x_right: pend_r_reg, has_span: 1'b1,
                                     last_of_row: 1'b0, overflow: ovf_reg, done_res: 1'b0};
                    end
                    pend_valid_next = 1'b1;
                    pend_l_next     = span_l_reg;
                    pend_r_next     = span_r_reg;
                    n_next          = n_reg + NW'(1);
                    idx_next        = idx_reg + CW'(2);
                    state_next      = ST_SPN_RD;
                end
            end

            ST_SPN_FIN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_next = '{row: row_reg[COORD_BITS-1:0], x_left: pend_l_reg,
                                     x_right: pend_r_reg, has_span: 1'b1,
                                     last_of_row: 1'b1, overflow: ovf_reg, done_res: 1'b0};
                    end
                    else
                    begin
                        out_next = '{row: row_reg[COORD_BITS-1:0], x_left: '0,
                                     x_right: '0, has_span: 1'b0,
                                     last_of_row: 1'b1, overflow: ovf_reg, done_res: 1'b0};
                    end
                    idx_next   = '0;
                    state_next = ST_ACT_RD;
                end
            end

            // activation scan over the edge store
            ST_ACT_RD:
            begin
                if (idx_reg < edge_cnt_reg)
                begin
                    state_next = ST_ACT_CHK;
                end
                else
                begin
                    idx_next   = '0;
                    keep_next  = '0;
                    state_next = ST_STP_RD;
                end
            end

            ST_ACT_CHK:
            begin
                if (({1'b0, e_yt} == row_reg) && (act_cnt_reg < CW'(MAX_EDGES)))
                begin
                    dx_s         = {1'b0, e_xb} - {1'b0, e_xt};
                    neg_next     = dx_s[COORD_BITS];
                    quo_next     = {(dx_s[COORD_BITS] ? (e_xt - e_xb) : (e_xb - e_xt)),
                                    {FRAC_BITS{1'b0}}};
                    rem_next     = '0;
                    dy_next      = e_yb - e_yt;
                    div_cnt_next = DCW'(NUM_W);
                    xt_next      = e_xt;
                    yb_next      = e_yb;
                    state_next   = ST_DIV;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = ST_ACT_RD;
                end
            end

            ST_DIV:
            begin
                if (div_rs >= {1'b0, dy_reg})
                begin
                    rem_next = COORD_BITS'(div_rs - {1'b0, dy_reg});
                    quo_next = {quo_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = div_rs[COORD_BITS-1:0];
                    quo_next = {quo_reg[NUM_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg - DCW'(1);
                if (div_cnt_reg == DCW'(1))
                begin
                    state_next = ST_ACT_WR;
                end
            end

            ST_ACT_WR:
            begin
                slope_w = ACC_W'(quo_reg);
                if (neg_reg)
                begin
                    slope_w = ACC_W'(0) - slope_w;
                end
                a_we = 1'b1;
                a_wa = act_cnt_reg[AW-1:0];
                a_wd = {ACC_W'({xt_reg, {FRAC_BITS{1'b0}}}), slope_w, yb_reg};
                act_cnt_next = act_cnt_reg + CW'(1);
                idx_next     = idx_reg + CW'(1);
                state_next   = ST_ACT_RD;
            end

            // retire finished edges, step the rest, compact in place
            ST_STP_RD:
            begin
                if (idx_reg < act_cnt_reg)
                begin
                    state_next = ST_STP_WR;
                end
                else
                begin
                    act_cnt_next = keep_reg;
                    state_next   = ST_SRT_START;
                end
            end

            ST_STP_WR:
            begin
                if ({1'b0, rd_end} != row_reg)
                begin
                    a_we      = 1'b1;
                    a_wa      = keep_reg[AW-1:0];
                    a_wd      = {step_x, rd_s, rd_end};
                    keep_next = keep_reg + CW'(1);
                end
                idx_next   = idx_reg + CW'(1);
                state_next = ST_STP_RD;
            end

            // stable bubble passes, largest x carried to the end
            ST_SRT_START:
            begin
                if (act_cnt_reg < CW'(2))
                begin
                    state_next = ST_NEXT_ROW;
                end
                else
                begin
                    a_ra       = '0;
                    swap_next  = 1'b0;
                    state_next = ST_SRT_LD0;
                end
            end

            ST_SRT_LD0:
            begin
                carry_next = a_rd_reg;
                idx_next   = CW'(1);
                state_next = ST_SRT_RD;
            end

            ST_SRT_RD:
            begin
                if (idx_reg < act_cnt_reg)
                begin
                    state_next = ST_SRT_CMP;
                end
                else
                begin
                    a_we       = 1'b1;
                    a_wa       = AW'(idx_reg - CW'(1));
                    a_wd       = carry_reg;
                    state_next = swap_reg ? ST_SRT_START : ST_NEXT_ROW;
                end
            end

            ST_SRT_CMP:
            begin
                a_we = 1'b1;
                a_wa = AW'(idx_reg - CW'(1));
                if (carry_x > rd_x)
                begin
                    a_wd      = a_rd_reg;
                    swap_next = 1'b1;
                end
                else
                begin
                    a_wd       = carry_reg;
                    carry_next = a_rd_reg;
                end
                idx_next   = idx_reg + CW'(1);
                state_next = ST_SRT_RD;
            end

            ST_NEXT_ROW:
            begin
                if (row_reg < ROW_MAX)
                begin
                    row_next = row_reg + CFG_BITS'(1);
                end
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            edge_cnt_reg   <= '0;
            act_cnt_reg    <= '0;
            row_reg        <= '0;
            ovf_reg        <= 1'b0;
            row_count_reg  <= ROW_COUNT_RST;
            line_width_reg <= LINE_WIDTH_RST;
            idx_reg        <= '0;
            keep_reg       <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            swap_reg       <= 1'b0;
            div_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            edge_cnt_reg   <= edge_cnt_next;
            act_cnt_reg    <= act_cnt_next;
            row_reg        <= row_next;
            ovf_reg        <= ovf_next;
            row_count_reg  <= row_count_next;
            line_width_reg <= line_width_next;
            idx_reg        <= idx_next;
            keep_reg       <= keep_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            swap_reg       <= swap_next;
            div_cnt_reg    <= div_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        pend_l_reg  <= pend_l_next;
        pend_r_reg  <= pend_r_next;
        span_ok_reg <= span_ok_next;
        span_l_reg  <= span_l_next;
        span_r_reg  <= span_r_next;
        xl_reg      <= xl_next;
        carry_reg   <= carry_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        dy_reg      <= dy_next;
        neg_reg     <= neg_next;
        xt_reg      <= xt_next;
        yb_reg      <= yb_next;
        out_reg     <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire
